// ----- hdl/vdo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdo_pkg
// Shared types and constants of the vertex degree ordering block.
// ----------------------------------------------------------------------------
package vdo_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int ROW_W        = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
    logic             store;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] n;
  } row_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEGREE,
    BK_EMIT
  } back_state_e;

endpackage
`default_nettype wire

// ----- hdl/vdo_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdo_front
// Accepts rows, numbers them and tags each with store and vertex count.
// ----------------------------------------------------------------------------
module vdo_front
  import vdo_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ROW_W-1:0] row_bits_i,
  input  wire logic             last_row_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output row_entry_t            entry_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             store;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign store      = cnt_q < CNT_W'(MAX_VERTICES);

  always_comb begin
    entry_o.row   = row_bits_i;
    entry_o.last  = last_row_i;
    entry_o.store = store;
    entry_o.idx   = cnt_q[IDX_W-1:0];
    entry_o.n     = store ? cnt_q + CNT_W'(1) : cnt_q;
    cnt_d         = cnt_q;
    if (push_o) begin
      if (last_row_i) begin
        cnt_d = '0;
      end else begin
        cnt_d = entry_o.n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/vdo_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdo_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module vdo_queue
  import vdo_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire row_entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output row_entry_t      entry_o
);

  row_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/vdo_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdo_back
// Row store, degree count, insertion chain and result output.
// ----------------------------------------------------------------------------
module vdo_back
  import vdo_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  output logic            q_pop_o,
  input  wire row_entry_t q_entry_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      vertex_index_o,
  output logic [4:0]      vertex_degree_o,
  output logic            last_vertex_o
);

  function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [2:0]       nib;
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < ROW_W / 4; b++) begin
      nib = '0;
      for (int j = 0; j < 4; j++) begin
        nib = nib + 3'(v[4*b+j]);
      end
      sum = sum + CNT_W'(nib);
    end
    return sum;
  endfunction

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [ROW_W-1:0] rows_q [MAX_VERTICES];
  logic [CNT_W-1:0] cdeg_q [MAX_VERTICES];
  logic [IDX_W-1:0] cidx_q [MAX_VERTICES];
  logic [ROW_W-1:0] mask;
  logic [CNT_W-1:0] new_deg;
  logic             at_end;
  logic             insert;
  logic             load;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] vidx_q;
  logic [CNT_W-1:0] vdeg_q;
  logic             vlast_q;

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = CNT_W'(j) < n_q;
    end
  end

  assign new_deg = popcount(rows_q[ptr_q] & mask);
  assign at_end  = CNT_W'(ptr_q) + CNT_W'(1) == n_q;
  assign q_pop_o = state_q == BK_IDLE;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    n_d         = n_q;
    insert      = 1'b0;
    load        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_entry_i.last) begin
          n_d     = q_entry_i.n;
          ptr_d   = '0;
          state_d = BK_DEGREE;
        end
      end
      BK_DEGREE: begin
        insert = 1'b1;
        ptr_d  = ptr_q + IDX_W'(1);
        if (at_end) begin
          ptr_d   = '0;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          ptr_d       = ptr_q + IDX_W'(1);
          if (at_end) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ptr_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_valid_i && q_entry_i.store) begin
      rows_q[q_entry_i.idx] <= q_entry_i.row;
    end
  end

  // Stable descending insertion; cells below ptr_q hold the sorted prefix.
  always_ff @(posedge clk_i) begin
    if (insert) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        if (k == 0) begin
          if (ptr_q == '0 || cdeg_q[0] < new_deg) begin
            cdeg_q[0] <= new_deg;
            cidx_q[0] <= ptr_q;
          end
        end else if (CNT_W'(k - 1) < CNT_W'(ptr_q)) begin
          if (cdeg_q[k-1] < new_deg) begin
            cdeg_q[k] <= cdeg_q[k-1];
            cidx_q[k] <= cidx_q[k-1];
          end else if (CNT_W'(k) >= CNT_W'(ptr_q) || cdeg_q[k] < new_deg) begin
            cdeg_q[k] <= new_deg;
            cidx_q[k] <= ptr_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vidx_q  <= cidx_q[ptr_q];
      vdeg_q  <= cdeg_q[ptr_q];
      vlast_q <= at_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = vidx_q;
  assign vertex_degree_o = vdeg_q;
  assign last_vertex_o   = vlast_q;

endmodule
`default_nettype wire

// ----- hdl/vertex_degree_order.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_degree_order
// Degree ordering of a graph given as adjacency rows, stable descending.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   row_bits, last_row
// out      output     out_valid / out_ready vertex_index, vertex_degree, last_vertex
//
// Rows are taken one per cycle while the 4-entry queue has room.
// A last row starts the back end on popcount and chain insertion for each vertex,
// one row store read per cycle, then results at one per cycle while out_ready holds.
// Reset clears counters, queue and state; the stores need no clearing.
// Either side may stall; the queue and output register decouple them.
// ----------------------------------------------------------------------------
module vertex_degree_order
  import vdo_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] row_bits_i,
  input  wire logic        last_row_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       vertex_index_o,
  output logic [4:0]       vertex_degree_o,
  output logic             last_vertex_o
);

  row_entry_t push_entry, pop_entry;
  logic       push, q_full, q_valid, q_pop;

  vdo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .row_bits_i (row_bits_i),
    .last_row_i (last_row_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  vdo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  vdo_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_entry_i       (pop_entry),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vertex_index_o  (vertex_index_o),
    .vertex_degree_o (vertex_degree_o),
    .last_vertex_o   (last_vertex_o)
  );

endmodule
`default_nettype wire

// ----- hdl/vdo_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdo_checker
// Port-level checks on the result stream of vertex_degree_order.
// ----------------------------------------------------------------------------
module vdo_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [3:0] vertex_index_o,
  input wire logic [4:0] vertex_degree_o,
  input wire logic       last_vertex_o
);

  logic       burst_q;
  logic [4:0] prev_deg_q;
  logic [3:0] prev_idx_q;
  logic       take;

  assign take = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q    <= 1'b0;
      prev_deg_q <= '0;
      prev_idx_q <= '0;
    end else if (take) begin
      burst_q    <= !last_vertex_o;
      prev_deg_q <= vertex_degree_o;
      prev_idx_q <= vertex_index_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertex_index_o)
      && $stable(vertex_degree_o) && $stable(last_vertex_o))
    else $error("result changed while stalled");

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vertex_degree_o <= 5'd16)
    else $error("degree out of range");

  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && burst_q |-> vertex_degree_o <= prev_deg_q)
    else $error("degrees not descending");

  a_stable_tie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && burst_q && vertex_degree_o == prev_deg_q
      |-> vertex_index_o > prev_idx_q)
    else $error("tie not in ascending index order");

endmodule

bind vertex_degree_order vdo_checker u_vdo_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .vertex_index_o  (vertex_index_o),
  .vertex_degree_o (vertex_degree_o),
  .last_vertex_o   (last_vertex_o)
);
`default_nettype wire
